// ===== src/mbsp_pkg.sv =====
// Package: shared types and constants for the MIDI byte stream parser.
package mbsp_pkg;

  localparam int unsigned SYSEX_MAX_COUNT_DEF = 1023;
  localparam int unsigned POS_W = 10;

  // Status byte codes
  localparam logic [7:0] ST_VOICE_LAST  = 8'hEF;
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_RT_FIRST    = 8'hF8;
  localparam logic [7:0] ST_RT_LAST     = 8'hFC;

  // Upper nibble of the running status
  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_POLY_PRES = 4'hA;
  localparam logic [3:0] HI_CC        = 4'hB;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_CHAN_PRES = 4'hD;
  localparam logic [3:0] HI_BEND      = 4'hE;

  // Data byte count codes
  localparam logic [1:0] DC_NONE   = 2'd0;
  localparam logic [1:0] DC_FIRST  = 2'd1;
  localparam logic [1:0] DC_SECOND = 2'd2;
  localparam logic [1:0] DC_BAD    = 2'd3;

  // Fine controller range and its coarse offset
  localparam logic [6:0] CC_FINE_LO   = 7'd32;
  localparam logic [6:0] CC_FINE_HI   = 7'd63;
  localparam logic [6:0] CC_FINE_OFS  = 7'd32;
  localparam logic [6:0] CC_NONE      = 7'd127;

  typedef enum logic [3:0] {
    KIND_REALTIME   = 4'd0,
    KIND_NOTE_ON    = 4'd1,
    KIND_NOTE_OFF   = 4'd2,
    KIND_CC         = 4'd3,
    KIND_CHAN_PRES  = 4'd4,
    KIND_PROGRAM    = 4'd5,
    KIND_POLY_PRES  = 4'd6,
    KIND_BEND       = 4'd7,
    KIND_SYSEX_DATA = 4'd8,
    KIND_SYSEX_END  = 4'd9
  } kind_t;

  typedef struct packed {
    logic [7:0] running_status;
    logic [1:0] data_count;
    logic [6:0] held_first_data;
    logic       sysex_active;
    logic [6:0] last_cc_number;
  } ctx_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       status_byte;
    logic [6:0]       first_data;
    logic [6:0]       second_data;
    logic [POS_W-1:0] sysex_position;
  } result_t;

endpackage

// ===== src/mbsp_decode.sv =====
// Decode of one received byte against the parser context.
module mbsp_decode #(
  parameter int unsigned SYSEX_MAX_COUNT = mbsp_pkg::SYSEX_MAX_COUNT_DEF,
  parameter int unsigned CNT_W           = $clog2(SYSEX_MAX_COUNT + 1)
) (
  input  logic [7:0]        rx_byte,
  input  mbsp_pkg::ctx_t    ctx,
  input  logic [CNT_W-1:0]  sysex_count,
  output mbsp_pkg::ctx_t    ctx_nxt,
  output logic [CNT_W-1:0]  sysex_count_nxt,
  output logic              res_valid,
  output mbsp_pkg::result_t res
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SYSEX_MAX_COUNT);

  logic [3:0]                        hi;
  logic [6:0]                        d;
  logic [CNT_W+mbsp_pkg::POS_W-1:0]  cnt_ext;
  logic [mbsp_pkg::POS_W-1:0]        pos;
  logic                              fine_cc;

  assign hi      = ctx.running_status[7:4];
  assign d       = rx_byte[6:0];
  // Report the count masked to the position width
  assign cnt_ext = {{mbsp_pkg::POS_W{1'b0}}, sysex_count};
  assign pos     = cnt_ext[mbsp_pkg::POS_W-1:0];
  assign fine_cc = (ctx.held_first_data >= mbsp_pkg::CC_FINE_LO) &&
                   (ctx.held_first_data <= mbsp_pkg::CC_FINE_HI) &&
                   (ctx.last_cc_number ==
                    (ctx.held_first_data - mbsp_pkg::CC_FINE_OFS));

  always_comb begin
    ctx_nxt             = ctx;
    sysex_count_nxt     = sysex_count;
    res_valid           = 1'b0;
    res.kind            = mbsp_pkg::KIND_REALTIME;
    res.status_byte     = ctx.running_status;
    res.first_data      = 7'd0;
    res.second_data     = 7'd0;
    res.sysex_position  = '0;
    if (rx_byte[7]) begin
      priority if (rx_byte <= mbsp_pkg::ST_VOICE_LAST) begin
        ctx_nxt.running_status = rx_byte;
        ctx_nxt.data_count     = mbsp_pkg::DC_FIRST;
        ctx_nxt.sysex_active   = 1'b0;
      end else if (rx_byte >= mbsp_pkg::ST_RT_FIRST && rx_byte <= mbsp_pkg::ST_RT_LAST) begin
        res_valid       = 1'b1;
        res.kind        = mbsp_pkg::KIND_REALTIME;
        res.status_byte = rx_byte;
      end else if (rx_byte == mbsp_pkg::ST_SYSEX_START) begin
        ctx_nxt.sysex_active = 1'b1;
        ctx_nxt.data_count   = mbsp_pkg::DC_FIRST;
        sysex_count_nxt      = '0;
      end else if (rx_byte == mbsp_pkg::ST_SYSEX_END && ctx.sysex_active) begin
        ctx_nxt.sysex_active = 1'b0;
        ctx_nxt.data_count   = mbsp_pkg::DC_NONE;
        res_valid            = 1'b1;
        res.kind             = mbsp_pkg::KIND_SYSEX_END;
        res.status_byte      = mbsp_pkg::ST_SYSEX_START;
        res.sysex_position   = pos;
      end else begin
        // drop other system bytes
      end
    end else if (ctx.sysex_active) begin
      if (sysex_count < CNT_MAX) begin
        sysex_count_nxt = sysex_count + CNT_W'(1);
      end
      res_valid          = 1'b1;
      res.kind           = mbsp_pkg::KIND_SYSEX_DATA;
      res.status_byte    = mbsp_pkg::ST_SYSEX_START;
      res.first_data     = d;
      res.sysex_position = pos;
    end else begin
      unique case (ctx.data_count)
        mbsp_pkg::DC_FIRST: begin
          if (hi == mbsp_pkg::HI_CHAN_PRES) begin
            res_valid      = 1'b1;
            res.kind       = mbsp_pkg::KIND_CHAN_PRES;
            res.first_data = d;
          end else if (hi == mbsp_pkg::HI_PROGRAM) begin
            res_valid      = 1'b1;
            res.kind       = mbsp_pkg::KIND_PROGRAM;
            res.first_data = d;
          end else begin
            ctx_nxt.held_first_data = d;
            ctx_nxt.data_count      = mbsp_pkg::DC_SECOND;
          end
        end
        mbsp_pkg::DC_SECOND: begin
          ctx_nxt.data_count = mbsp_pkg::DC_FIRST;
          res.first_data     = ctx.held_first_data;
          priority if (hi == mbsp_pkg::HI_NOTE_ON && d != 7'd0) begin
            res_valid       = 1'b1;
            res.kind        = mbsp_pkg::KIND_NOTE_ON;
            res.second_data = d;
          end else if (hi == mbsp_pkg::HI_NOTE_OFF || hi == mbsp_pkg::HI_NOTE_ON) begin
            res_valid = 1'b1;
            res.kind  = mbsp_pkg::KIND_NOTE_OFF;
          end else if (hi == mbsp_pkg::HI_CC) begin
            // suppress the fine half right after its coarse partner
            ctx_nxt.last_cc_number = ctx.held_first_data;
            res_valid              = !fine_cc;
            res.kind               = mbsp_pkg::KIND_CC;
            res.second_data        = d;
          end else if (hi == mbsp_pkg::HI_POLY_PRES) begin
            res_valid       = 1'b1;
            res.kind        = mbsp_pkg::KIND_POLY_PRES;
            res.second_data = d;
          end else if (hi == mbsp_pkg::HI_BEND) begin
            res_valid       = 1'b1;
            res.kind        = mbsp_pkg::KIND_BEND;
            res.second_data = d;
          end else begin
            res_valid = 1'b0;
          end
        end
        default: begin
          // no status in force (none yet, or after a sysex end), or a count that cannot arise: drop the byte
        end
      endcase
    end
  end

endmodule

// ===== src/mbsp_out_stage.sv =====
// Result register with valid/stall handshake toward the consumer.
module mbsp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              res_valid,
  input  mbsp_pkg::result_t res,
  input  logic              out_stall,
  output logic              can_take,
  output logic              out_valid,
  output mbsp_pkg::result_t out_res
);

  logic              valid_r;
  logic              valid_nxt;
  mbsp_pkg::result_t res_r;

  // Free when empty or when the held result transfers this cycle
  assign can_take = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (can_take) begin
      valid_nxt = advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid && can_take) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== src/midi_byte_stream_parser_core.sv =====
// Top level: MIDI byte stream parser with running status and sysex collection.
// One MIDI byte is taken per cycle while the result register is not stalled;
// each byte passes an input register, one pass of decode logic that also
// updates the parser context, and a result register. Bytes that complete no
// message (voice and sysex start status bytes, first data bytes of two-data
// messages, suppressed fine controllers, ignored system bytes) give no
// result. Only a stalled result register holds back input. Sysex positions
// count up to SYSEX_MAX_COUNT and then hold; positions are reported on 10 bits.
module midi_byte_stream_parser_core #(
  parameter int unsigned SYSEX_MAX_COUNT = mbsp_pkg::SYSEX_MAX_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_kind,
  output logic [7:0] out_status_byte,
  output logic [6:0] out_first_data,
  output logic [6:0] out_second_data,
  output logic [9:0] out_sysex_position
);

  localparam int unsigned CNT_W = $clog2(SYSEX_MAX_COUNT + 1);

  logic              in_valid_r;
  logic              in_valid_nxt;
  logic [7:0]        in_byte_r;
  logic              in_take;
  logic              advance;
  logic              can_take;
  mbsp_pkg::ctx_t    ctx_r;
  mbsp_pkg::ctx_t    ctx_nxt;
  logic [CNT_W-1:0]  sysex_count_r;
  logic [CNT_W-1:0]  sysex_count_nxt;
  logic              res_valid;
  mbsp_pkg::result_t res;
  mbsp_pkg::result_t out_res;

  assign advance  = in_valid_r && can_take;
  assign in_stall = in_valid_r && !can_take;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Context moves only when the held byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.running_status  <= '0;
      ctx_r.data_count      <= mbsp_pkg::DC_NONE;
      ctx_r.held_first_data <= '0;
      ctx_r.sysex_active    <= 1'b0;
      ctx_r.last_cc_number  <= mbsp_pkg::CC_NONE;
      sysex_count_r         <= '0;
    end else if (advance) begin
      ctx_r         <= ctx_nxt;
      sysex_count_r <= sysex_count_nxt;
    end
  end

  mbsp_decode #(
    .SYSEX_MAX_COUNT (SYSEX_MAX_COUNT),
    .CNT_W           (CNT_W)
  ) u_decode (
    .rx_byte         (in_byte_r),
    .ctx             (ctx_r),
    .sysex_count     (sysex_count_r),
    .ctx_nxt         (ctx_nxt),
    .sysex_count_nxt (sysex_count_nxt),
    .res_valid       (res_valid),
    .res             (res)
  );

  mbsp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_status_byte    = out_res.status_byte;
  assign out_first_data     = out_res.first_data;
  assign out_second_data    = out_res.second_data;
  assign out_sysex_position = out_res.sysex_position;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !in_valid_r && !out_valid)
    else $error("pipeline not empty after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sysex_count_r <= CNT_W'(SYSEX_MAX_COUNT))
    else $error("sysex count above its maximum");

  a_dc_legal: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.data_count != mbsp_pkg::DC_BAD)
    else $error("illegal data count");

  a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_byte_r) && $stable(ctx_r))
    else $error("held byte or context changed while blocked");

  a_sysex_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == mbsp_pkg::KIND_SYSEX_DATA ||
                  out_kind == mbsp_pkg::KIND_SYSEX_END)
      |-> out_status_byte == mbsp_pkg::ST_SYSEX_START)
    else $error("sysex result without sysex status");
`endif

endmodule

// ===== dv/midi_byte_stream_parser_core_tb.sv =====
// Testbench for midi_byte_stream_parser_core: directed and random MIDI byte streams.
`timescale 1ns / 1ps

module midi_byte_stream_parser_core_tb;

  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 700;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SYSEX_LONG     = mbsp_pkg::SYSEX_MAX_COUNT_DEF + 7;

  // Ignored bytes, realtime, every message kind, fine CC suppression, sysex with realtime
  localparam logic [7:0] OPENING_BYTES [32] = '{
    8'h00, 8'h7F, mbsp_pkg::ST_SYSEX_END, 8'hF1, 8'hFF, mbsp_pkg::ST_RT_FIRST,
    mbsp_pkg::ST_RT_LAST,
    {mbsp_pkg::HI_NOTE_ON, 4'h0}, 8'h3C, 8'h64, 8'h3C, 8'h00,
    {mbsp_pkg::HI_CC, 4'h3}, 8'h07, 8'h40, 8'h27, 8'h10,
    {mbsp_pkg::HI_PROGRAM, 4'h5}, 8'h7F, {mbsp_pkg::HI_CHAN_PRES, 4'hF}, 8'h00,
    {mbsp_pkg::HI_POLY_PRES, 4'hA}, 8'h40, 8'h7F, {mbsp_pkg::HI_BEND, 4'hF}, 8'h00, 8'h7F,
    mbsp_pkg::ST_SYSEX_START, 8'h01, mbsp_pkg::ST_RT_FIRST, 8'h7F, mbsp_pkg::ST_SYSEX_END
  };

  class midi_decode_board;
    logic [7:0]        run_status;
    logic [1:0]        byte_slot;
    logic [6:0]        held_data;
    bit                in_sysex;
    logic [9:0]        sysex_pos;
    logic [6:0]        prev_cc;
    mbsp_pkg::result_t decoded_events[$];
    int                errors;

    function new();
      run_status = '0;
      byte_slot  = mbsp_pkg::DC_NONE;
      held_data  = '0;
      in_sysex   = 1'b0;
      sysex_pos  = '0;
      prev_cc    = mbsp_pkg::CC_NONE;
      errors     = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void post(mbsp_pkg::kind_t k, logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                       logic [9:0] pos);
      mbsp_pkg::result_t r;
      r.kind           = k;
      r.status_byte    = st;
      r.first_data     = d1;
      r.second_data    = d2;
      r.sysex_position = pos;
      decoded_events.push_back(r);
    endfunction

    // Decode one accepted byte and queue the message it completes, if any.
    function void note_byte(logic [7:0] b);
      logic [3:0] hi;
      bit         fine;
      hi = run_status[7:4];
      if (b[7]) begin
        if (b <= mbsp_pkg::ST_VOICE_LAST) begin
          run_status = b;
          byte_slot  = mbsp_pkg::DC_FIRST;
          in_sysex   = 1'b0;
        end else if (b >= mbsp_pkg::ST_RT_FIRST && b <= mbsp_pkg::ST_RT_LAST) begin
          post(mbsp_pkg::KIND_REALTIME, b, '0, '0, '0);
        end else if (b == mbsp_pkg::ST_SYSEX_START) begin
          in_sysex  = 1'b1;
          sysex_pos = '0;
          byte_slot = mbsp_pkg::DC_FIRST;
        end else if (b == mbsp_pkg::ST_SYSEX_END && in_sysex) begin
          in_sysex  = 1'b0;
          byte_slot = mbsp_pkg::DC_NONE;
          post(mbsp_pkg::KIND_SYSEX_END, mbsp_pkg::ST_SYSEX_START, '0, '0, sysex_pos);
        end
      end else if (in_sysex) begin
        post(mbsp_pkg::KIND_SYSEX_DATA, mbsp_pkg::ST_SYSEX_START, b[6:0], '0, sysex_pos);
        if (sysex_pos < mbsp_pkg::SYSEX_MAX_COUNT_DEF) sysex_pos++;
      end else if (byte_slot == mbsp_pkg::DC_FIRST) begin
        if (hi == mbsp_pkg::HI_CHAN_PRES)
          post(mbsp_pkg::KIND_CHAN_PRES, run_status, b[6:0], '0, '0);
        else if (hi == mbsp_pkg::HI_PROGRAM)
          post(mbsp_pkg::KIND_PROGRAM, run_status, b[6:0], '0, '0);
        else begin
          held_data = b[6:0];
          byte_slot = mbsp_pkg::DC_SECOND;
        end
      end else if (byte_slot == mbsp_pkg::DC_SECOND) begin
        byte_slot = mbsp_pkg::DC_FIRST;
        case (hi)
          mbsp_pkg::HI_NOTE_ON: begin
            if (b != 0) post(mbsp_pkg::KIND_NOTE_ON, run_status, held_data, b[6:0], '0);
            else post(mbsp_pkg::KIND_NOTE_OFF, run_status, held_data, '0, '0);
          end
          mbsp_pkg::HI_NOTE_OFF: post(mbsp_pkg::KIND_NOTE_OFF, run_status, held_data, '0, '0);
          mbsp_pkg::HI_CC: begin
            // drop a fine controller that directly follows its coarse partner
            fine = held_data >= mbsp_pkg::CC_FINE_LO && held_data <= mbsp_pkg::CC_FINE_HI &&
                   prev_cc == held_data - mbsp_pkg::CC_FINE_OFS;
            prev_cc = held_data;
            if (!fine) post(mbsp_pkg::KIND_CC, run_status, held_data, b[6:0], '0);
          end
          mbsp_pkg::HI_POLY_PRES:
            post(mbsp_pkg::KIND_POLY_PRES, run_status, held_data, b[6:0], '0);
          mbsp_pkg::HI_BEND: post(mbsp_pkg::KIND_BEND, run_status, held_data, b[6:0], '0);
          default: ;
        endcase
      end
    endfunction

    function void check_result(mbsp_pkg::result_t got);
      mbsp_pkg::result_t want;
      if (decoded_events.size() == 0) begin
        flag($sformatf("ERROR: result with none pending: kind=%0d status=%h d1=%h d2=%h pos=%0d",
                       got.kind, got.status_byte, got.first_data, got.second_data,
                       got.sysex_position));
        return;
      end
      want = decoded_events.pop_front();
      if (got.kind !== want.kind || got.status_byte !== want.status_byte ||
          got.first_data !== want.first_data || got.second_data !== want.second_data ||
          got.sysex_position !== want.sysex_position)
        flag($sformatf({"ERROR: mismatch: expected kind=%0d status=%h d1=%h d2=%h pos=%0d",
                        " got kind=%0d status=%h d1=%h d2=%h pos=%0d"},
                       want.kind, want.status_byte, want.first_data, want.second_data,
                       want.sysex_position, got.kind, got.status_byte, got.first_data,
                       got.second_data, got.sysex_position));
    endfunction

    function int pending();
      return decoded_events.size();
    endfunction

    function void close_out();
      if (decoded_events.size() != 0)
        flag($sformatf("ERROR: %0d results never arrived", decoded_events.size()));
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] out_kind;
  logic [7:0] out_status_byte;
  logic [6:0] out_first_data;
  logic [6:0] out_second_data;
  logic [9:0] out_sysex_position;

  midi_decode_board board;
  bit quiet;
  int n_sent;
  int idle_cycles;

  midi_byte_stream_parser_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_status_byte    (out_status_byte),
    .out_first_data     (out_first_data),
    .out_second_data    (out_second_data),
    .out_sysex_position (out_sysex_position)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= rst_n && !quiet && ($urandom_range(99) < 9);
  end

  // Monitor both channels on pre-edge values.
  always @(posedge clk) begin : monitor
    mbsp_pkg::result_t got;
    bit                moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        board.note_byte(in_rx_byte);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got.kind           = mbsp_pkg::kind_t'(out_kind);
        got.status_byte    = out_status_byte;
        got.first_data     = out_first_data;
        got.second_data    = out_second_data;
        got.sysex_position = out_sysex_position;
        board.check_result(got);
        moved = 1'b1;
      end
    end
    if (moved || !rst_n) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  function automatic logic [7:0] data_byte();
    return {1'b0, 7'($urandom)};
  endfunction

  initial begin : stimulus
    int         pick;
    int         n_ignored;
    int         len;
    bit         voice_prev;
    bit         paused;
    logic [7:0] status;
    logic [6:0] num;
    logic [7:0] val;

    board       = new();
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = '0;
    out_stall   = 1'b0;
    quiet       = 1'b0;
    n_sent      = 0;
    idle_cycles = 0;
    n_ignored   = 0;
    voice_prev  = 1'b0;
    paused      = 1'b0;
    status      = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);

    // Long sysex drives the position counter into saturation.
    send_byte(mbsp_pkg::ST_SYSEX_START);
    repeat (SYSEX_LONG) send_byte(data_byte());
    send_byte(mbsp_pkg::ST_SYSEX_END);

    n_sent = 0;
    while (n_sent - n_ignored < RANDOM_ITEMS) begin
      quiet = (n_sent >= 200 && n_sent < 320);
      if (!paused && n_sent >= 400) begin
        // hold until the pipeline has handed over everything
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        if (!voice_prev || $urandom_range(2) == 0) begin
          status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
          send_byte(status);
        end
        case (status[7:4])
          mbsp_pkg::HI_PROGRAM, mbsp_pkg::HI_CHAN_PRES: send_byte(data_byte());
          mbsp_pkg::HI_CC: begin
            num = 7'($urandom);
            val = data_byte();
            if ($urandom_range(2) == 0) begin
              num[6:5] = 2'b00;
              send_byte({1'b0, num});
              send_byte(val);
              send_byte({1'b0, num + mbsp_pkg::CC_FINE_OFS});
              send_byte(data_byte());
            end else begin
              send_byte({1'b0, num});
              send_byte(val);
            end
          end
          mbsp_pkg::HI_NOTE_ON: begin
            send_byte(data_byte());
            send_byte(($urandom_range(3) == 0) ? 8'h00 : data_byte());
          end
          default: begin
            send_byte(data_byte());
            send_byte(data_byte());
          end
        endcase
        voice_prev = 1'b1;
      end else if (pick < 75) begin
        send_byte(mbsp_pkg::ST_SYSEX_START);
        len = $urandom_range(0, 8);
        repeat (len) begin
          if ($urandom_range(9) == 0)
            send_byte(8'($urandom_range(mbsp_pkg::ST_RT_FIRST, mbsp_pkg::ST_RT_LAST)));
          send_byte(data_byte());
        end
        if ($urandom_range(5) == 0) begin
          // cut the sysex short with a new voice status
          status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
          send_byte(status);
          voice_prev = 1'b1;
        end else begin
          send_byte(mbsp_pkg::ST_SYSEX_END);
          voice_prev = 1'b0;
        end
      end else if (pick < 85) begin
        send_byte(8'($urandom_range(mbsp_pkg::ST_RT_FIRST, mbsp_pkg::ST_RT_LAST)));
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        n_ignored++;
        voice_prev = 1'b0;
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.close_out();
    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
